/* rtl/gsp_pkg.sv */
package gsp_pkg;

  localparam int POOL_SLOTS_DEF = 128;
  localparam int GEN_BITS_DEF   = 16;
  localparam int CAP_MAX        = 128;

  localparam int CMD_W  = 2;
  localparam int SIN_W  = 8;
  localparam int GIN_W  = 16;
  localparam int STAT_W = 2;
  localparam int SOUT_W = 7;
  localparam int GOUT_W = 16;
  localparam int CNT_W  = 8;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_STALE = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

/* rtl/gsp_ctrl.sv */
module gsp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output gsp_pkg::ctrl_cmd_t cmd
);

  gsp_pkg::state_t state_r;
  gsp_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gsp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gsp_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = gsp_pkg::ST_EXEC;
        end
      end
      gsp_pkg::ST_EXEC: begin
        state_nxt = gsp_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gsp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    unique case (state_r)
      gsp_pkg::ST_IDLE: begin
        cmd.load = start;
      end
      gsp_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        busy     = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec)
    else $error("accepted item not executed next cycle");

  a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> !cmd.exec)
    else $error("execute held for more than one cycle");

  a_busy_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.load)
    else $error("item loaded while busy");

endmodule

/* rtl/gsp_dpath.sv */
module gsp_dpath #(
  parameter int POOL_SLOTS = gsp_pkg::POOL_SLOTS_DEF,
  parameter int GEN_BITS   = gsp_pkg::GEN_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gsp_pkg::ctrl_cmd_t          cmd,
  input  logic [gsp_pkg::CMD_W-1:0]   in_command,
  input  logic [gsp_pkg::SIN_W-1:0]   in_slot_index,
  input  logic [gsp_pkg::GIN_W-1:0]   in_generation,
  input  logic                        cfg_we,
  input  logic [gsp_pkg::CNT_W-1:0]   cfg_data,
  output logic                        out_valid,
  output logic [gsp_pkg::STAT_W-1:0]  out_status,
  output logic [gsp_pkg::SOUT_W-1:0]  out_handle_slot,
  output logic [gsp_pkg::GOUT_W-1:0]  out_handle_generation,
  output logic [gsp_pkg::CNT_W-1:0]   out_live_count
);

  localparam int CAP   = (POOL_SLOTS < gsp_pkg::CAP_MAX) ? POOL_SLOTS : gsp_pkg::CAP_MAX;
  localparam int IDX_W = $clog2(CAP);

  // generation store
  logic [GEN_BITS-1:0] gen_mem [CAP];

  logic [gsp_pkg::CNT_W-1:0]  cap_r;
  logic [CAP-1:0]             occ_r;
  logic [CAP-1:0]             gvld_r;
  logic [gsp_pkg::CNT_W-1:0]  live_r;

  logic [gsp_pkg::CMD_W-1:0]  cmd_r;
  logic [gsp_pkg::SIN_W-1:0]  slot_r;
  logic [gsp_pkg::GIN_W-1:0]  ingen_r;
  logic [IDX_W-1:0]           tgt_r;
  logic                       hit_r;
  logic                       vld_r;
  logic [GEN_BITS-1:0]        rd_gen_r;

  logic                       out_valid_r;
  logic [gsp_pkg::STAT_W-1:0] out_status_r;
  logic [gsp_pkg::SOUT_W-1:0] out_slot_r;
  logic [gsp_pkg::GOUT_W-1:0] out_gen_r;

  logic [CAP-1:0]             avail;
  logic [IDX_W-1:0]           ffz;
  logic                       any_free;
  logic [IDX_W-1:0]           rd_addr;
  logic                       in_range;
  logic                       cfg_ok;

  logic [GEN_BITS-1:0]        stored;
  logic [GEN_BITS-1:0]        bump;
  logic                       live_ok;
  logic                       set_occ;
  logic                       clr_occ;
  logic [gsp_pkg::CNT_W-1:0]  live_nxt;
  logic [gsp_pkg::STAT_W-1:0] status_nxt;
  logic [gsp_pkg::SOUT_W-1:0] slot_nxt;
  logic [gsp_pkg::GOUT_W-1:0] gen_nxt;

  // lowest free slot below capacity
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      avail[i] = !occ_r[i] && (gsp_pkg::CNT_W'(i) < cap_r);
    end
    ffz = '0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (avail[i]) begin
        ffz = IDX_W'(i);
      end
    end
    any_free = |avail;
  end

  assign in_range = in_slot_index < cap_r;
  assign rd_addr  = (in_command == gsp_pkg::CMD_ALLOC) ? ffz : in_slot_index[IDX_W-1:0];
  assign cfg_ok   = cfg_we && (cfg_data != '0) && (cfg_data <= gsp_pkg::CNT_W'(CAP));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_command;
      slot_r   <= in_slot_index;
      ingen_r  <= in_generation;
      tgt_r    <= rd_addr;
      hit_r    <= (in_command == gsp_pkg::CMD_ALLOC) ? any_free : in_range;
      vld_r    <= gvld_r[rd_addr];
      rd_gen_r <= gen_mem[rd_addr];
    end
    if (set_occ) begin
      gen_mem[tgt_r] <= bump;
    end
  end

  always_comb begin
    stored = vld_r ? rd_gen_r : '0;
    bump   = stored + GEN_BITS'(1);
    if (bump == '0) begin
      bump = GEN_BITS'(1);
    end
    live_ok    = hit_r && occ_r[tgt_r] && (stored == GEN_BITS'(ingen_r));
    set_occ    = 1'b0;
    clr_occ    = 1'b0;
    live_nxt   = live_r;
    status_nxt = gsp_pkg::STAT_STALE;
    slot_nxt   = slot_r[gsp_pkg::SOUT_W-1:0];
    gen_nxt    = ingen_r;
    unique case (cmd_r)
      gsp_pkg::CMD_ALLOC: begin
        if (hit_r) begin
          set_occ    = cmd.exec;
          live_nxt   = live_r + gsp_pkg::CNT_W'(1);
          status_nxt = gsp_pkg::STAT_OK;
          slot_nxt   = gsp_pkg::SOUT_W'(tgt_r);
          gen_nxt    = gsp_pkg::GOUT_W'(bump);
        end else begin
          status_nxt = gsp_pkg::STAT_FULL;
          slot_nxt   = '0;
          gen_nxt    = '0;
        end
      end
      gsp_pkg::CMD_RELEASE: begin
        if (live_ok) begin
          clr_occ    = cmd.exec;
          status_nxt = gsp_pkg::STAT_OK;
          if (live_r != '0) begin
            live_nxt = live_r - gsp_pkg::CNT_W'(1);
          end
        end
      end
      gsp_pkg::CMD_LOOKUP: begin
        if (live_ok) begin
          status_nxt = gsp_pkg::STAT_OK;
        end
      end
      default: begin
        slot_nxt = '0;
        gen_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= gsp_pkg::CNT_W'(CAP);
      occ_r       <= '0;
      gvld_r      <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
      priority if (cfg_ok) begin
        cap_r  <= cfg_data;
        occ_r  <= '0;
        gvld_r <= '0;
        live_r <= '0;
      end else if (cmd.exec) begin
        live_r <= live_nxt;
        if (set_occ) begin
          occ_r[tgt_r]  <= 1'b1;
          gvld_r[tgt_r] <= 1'b1;
        end
        if (clr_occ) begin
          occ_r[tgt_r] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status_r <= status_nxt;
      out_slot_r   <= slot_nxt;
      out_gen_r    <= gen_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_handle_slot       = out_slot_r;
  assign out_handle_generation = out_gen_r;
  assign out_live_count        = live_r;

  a_live_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
    live_r == gsp_pkg::CNT_W'($countones(occ_r)))
    else $error("live count out of step with occupancy");

  a_cap_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_r != '0) && (cap_r <= gsp_pkg::CNT_W'(CAP)))
    else $error("capacity register out of range");

  a_occ_has_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r & ~gvld_r) == '0)
    else $error("occupied slot without a written generation");

endmodule

/* rtl/generational_slot_pool.sv */
// Generational slot pool: allocate, release and look up handles made of a slot
// index and a generation. A command is taken when start is high and busy is low;
// each command is loaded with the generation memory read, then checked and
// written back in the execute step, while busy is high, so a new
// command may follow right after. The result shows on the out_ ports for exactly
// one cycle, marked by out_valid, in the cycle right after the busy cycle; there
// is no way to stall it, so the receiver must take it then. out_live_count shows
// the occupancy continuously and matches the result when out_valid is high.
// A cfg_we write of a capacity from 1 to the pool size (at most 128) takes effect
// at once and clears all slots and generations; other values are ignored. Write
// it only while no command is in flight.
module generational_slot_pool #(
  parameter int POOL_SLOTS = gsp_pkg::POOL_SLOTS_DEF,
  parameter int GEN_BITS   = gsp_pkg::GEN_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [gsp_pkg::CMD_W-1:0]   in_command,
  input  logic [gsp_pkg::SIN_W-1:0]   in_slot_index,
  input  logic [gsp_pkg::GIN_W-1:0]   in_generation,
  input  logic                        cfg_we,
  input  logic [gsp_pkg::CNT_W-1:0]   cfg_data,
  output logic                        out_valid,
  output logic [gsp_pkg::STAT_W-1:0]  out_status,
  output logic [gsp_pkg::SOUT_W-1:0]  out_handle_slot,
  output logic [gsp_pkg::GOUT_W-1:0]  out_handle_generation,
  output logic [gsp_pkg::CNT_W-1:0]   out_live_count
);

  gsp_pkg::ctrl_cmd_t ctl;

  gsp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (ctl)
  );

  gsp_dpath #(
    .POOL_SLOTS (POOL_SLOTS),
    .GEN_BITS   (GEN_BITS)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (ctl),
    .in_command            (in_command),
    .in_slot_index         (in_slot_index),
    .in_generation         (in_generation),
    .cfg_we                (cfg_we),
    .cfg_data              (cfg_data),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_handle_slot       (out_handle_slot),
    .out_handle_generation (out_handle_generation),
    .out_live_count        (out_live_count)
  );

endmodule

/* dv/tb_generational_slot_pool.sv */
module tb_generational_slot_pool;

  localparam logic [gsp_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 200;

  typedef enum logic [1:0] {
    OP_CMD,
    OP_CAP_WRITE,
    OP_SETTLE
  } pool_op_kind_t;

  typedef struct {
    pool_op_kind_t              kind;
    logic [gsp_pkg::CMD_W-1:0]  cmd;
    logic [gsp_pkg::SIN_W-1:0]  slot;
    logic [gsp_pkg::GIN_W-1:0]  gen;
    logic [gsp_pkg::CNT_W-1:0]  cap;
  } pool_op_t;

  typedef struct packed {
    logic [gsp_pkg::STAT_W-1:0] status;
    logic [gsp_pkg::SOUT_W-1:0] slot;
    logic [gsp_pkg::GOUT_W-1:0] gen;
    logic [gsp_pkg::CNT_W-1:0]  live;
  } pool_reply_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [gsp_pkg::CMD_W-1:0]  in_command = '0;
  logic [gsp_pkg::SIN_W-1:0]  in_slot_index = '0;
  logic [gsp_pkg::GIN_W-1:0]  in_generation = '0;
  logic                       cfg_we = 1'b0;
  logic [gsp_pkg::CNT_W-1:0]  cfg_data = '0;
  logic                       out_valid;
  logic [gsp_pkg::STAT_W-1:0] out_status;
  logic [gsp_pkg::SOUT_W-1:0] out_handle_slot;
  logic [gsp_pkg::GOUT_W-1:0] out_handle_generation;
  logic [gsp_pkg::CNT_W-1:0]  out_live_count;

  generational_slot_pool u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_command            (in_command),
    .in_slot_index         (in_slot_index),
    .in_generation         (in_generation),
    .cfg_we                (cfg_we),
    .cfg_data              (cfg_data),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_handle_slot       (out_handle_slot),
    .out_handle_generation (out_handle_generation),
    .out_live_count        (out_live_count)
  );

  always #4 clk = ~clk;

  // shadow of the pool
  bit                      slot_busy [gsp_pkg::CAP_MAX];
  bit [gsp_pkg::GIN_W-1:0] slot_gen [gsp_pkg::CAP_MAX];
  bit [gsp_pkg::CNT_W-1:0] live_total = '0;
  bit [gsp_pkg::CNT_W-1:0] cap_now = gsp_pkg::CNT_W'(gsp_pkg::CAP_MAX);

  pool_op_t    op_q[$];
  pool_reply_t reply_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          gap_left = 0;
  int          settle_cnt = 0;
  bit          steady = 1'b0;

  function automatic bit handle_live(logic [gsp_pkg::SIN_W-1:0] s,
                                     logic [gsp_pkg::GIN_W-1:0] g);
    return s < cap_now && slot_busy[s[6:0]] && slot_gen[s[6:0]] == g;
  endfunction

  function automatic void write_capacity(logic [gsp_pkg::CNT_W-1:0] v);
    if (v == 0 || v > gsp_pkg::CAP_MAX) return;
    cap_now = v;
    live_total = '0;
    for (int k = 0; k < gsp_pkg::CAP_MAX; k++) begin
      slot_busy[k] = 1'b0;
      slot_gen[k] = '0;
    end
  endfunction

  function automatic pool_reply_t run_pool_command(logic [gsp_pkg::CMD_W-1:0] c,
                                                   logic [gsp_pkg::SIN_W-1:0] s,
                                                   logic [gsp_pkg::GIN_W-1:0] g);
    pool_reply_t r;
    logic [gsp_pkg::GIN_W-1:0] ng;
    bit found;
    r = '{gsp_pkg::STAT_STALE, '0, '0, '0};
    found = 1'b0;
    case (c)
      gsp_pkg::CMD_ALLOC: begin
        r.status = gsp_pkg::STAT_FULL;
        for (int k = 0; k < cap_now && !found; k++) begin
          if (!slot_busy[k]) begin
            ng = slot_gen[k] + gsp_pkg::GIN_W'(1);
            if (ng == 0) ng = gsp_pkg::GIN_W'(1);
            slot_gen[k] = ng;
            slot_busy[k] = 1'b1;
            live_total++;
            found = 1'b1;
            r.status = gsp_pkg::STAT_OK;
            r.slot = 7'(k);
            r.gen = ng;
          end
        end
      end
      gsp_pkg::CMD_RELEASE: begin
        r.slot = s[6:0];
        r.gen = g;
        if (handle_live(s, g)) begin
          slot_busy[s[6:0]] = 1'b0;
          if (live_total != 0) live_total--;
          r.status = gsp_pkg::STAT_OK;
        end
      end
      gsp_pkg::CMD_LOOKUP: begin
        r.slot = s[6:0];
        r.gen = g;
        if (handle_live(s, g)) r.status = gsp_pkg::STAT_OK;
      end
      default: ;
    endcase
    r.live = live_total;
    return r;
  endfunction

  // driver
  logic taken, start_nxt, we_nxt, all_quiet;
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      gap_left <= 0;
      settle_cnt <= 0;
    end else begin
      taken = start && !busy;
      start_nxt = start && !taken;
      we_nxt = 1'b0;
      all_quiet = !start && !busy && !out_valid && !cfg_we && reply_q.size() == 0;
      settle_cnt <= all_quiet ? settle_cnt + 1 : 0;
      if (!start_nxt) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_command <= gsp_pkg::CMD_W'($urandom);
          in_slot_index <= gsp_pkg::SIN_W'($urandom);
          in_generation <= gsp_pkg::GIN_W'($urandom);
        end else if (op_q.size() != 0) begin
          case (op_q[0].kind)
            OP_CMD: begin
              start_nxt = 1'b1;
              in_command <= op_q[0].cmd;
              in_slot_index <= op_q[0].slot;
              in_generation <= op_q[0].gen;
              void'(op_q.pop_front());
              if (!steady && $urandom_range(0, 3) == 0)
                gap_left <= $urandom_range(1, 11);
            end
            OP_CAP_WRITE: begin
              if (all_quiet && settle_cnt >= 3) begin
                we_nxt = 1'b1;
                cfg_data <= op_q[0].cap;
                void'(op_q.pop_front());
              end
            end
            default: begin
              if (all_quiet && settle_cnt >= 3) void'(op_q.pop_front());
            end
          endcase
        end
      end
      start <= start_nxt;
      cfg_we <= we_nxt;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    pool_reply_t want, got;
    if (rst_n) begin
      got = '{out_status, out_handle_slot, out_handle_generation, out_live_count};
      if (out_valid) begin
        if (reply_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: st=%0d slot=%0d gen=%0d live=%0d",
                     got.status, got.slot, got.gen, got.live);
        end else begin
          want = reply_q.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.gen !== want.gen || got.live !== want.live) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: want st=%0d slot=%0d gen=%0d live=%0d, ",
                        "got st=%0d slot=%0d gen=%0d live=%0d"},
                       want.status, want.slot, want.gen, want.live,
                       got.status, got.slot, got.gen, got.live);
          end
        end
      end
      if (cfg_we) write_capacity(cfg_data);
      if (start && !busy)
        reply_q.insert(reply_q.size(),
                       run_pool_command(in_command, in_slot_index, in_generation));
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("generational_slot_pool regression: fail");
      $finish;
    end
  end

  task automatic queue_cmd(logic [gsp_pkg::CMD_W-1:0] c, logic [gsp_pkg::SIN_W-1:0] s,
                           logic [gsp_pkg::GIN_W-1:0] g);
    op_q.insert(op_q.size(), '{OP_CMD, c, s, g, '0});
  endtask

  task automatic queue_cap(logic [gsp_pkg::CNT_W-1:0] v);
    op_q.insert(op_q.size(), '{OP_CAP_WRITE, CMD_NONE, '0, '0, v});
  endtask

  function automatic bit pick_live(output logic [gsp_pkg::SIN_W-1:0] s,
                                   output logic [gsp_pkg::GIN_W-1:0] g);
    int base, idx;
    base = $urandom_range(0, cap_now - 1);
    for (int k = 0; k < cap_now; k++) begin
      idx = (base + k) % cap_now;
      if (slot_busy[idx]) begin
        s = idx[gsp_pkg::SIN_W-1:0];
        g = slot_gen[idx];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic queue_random_item(int alloc_pct);
    logic [gsp_pkg::SIN_W-1:0] s;
    logic [gsp_pkg::GIN_W-1:0] g;
    logic [gsp_pkg::CMD_W-1:0] c;
    int r;
    s = gsp_pkg::SIN_W'($urandom);
    g = gsp_pkg::GIN_W'($urandom);
    c = $urandom_range(0, 1) ? gsp_pkg::CMD_RELEASE : gsp_pkg::CMD_LOOKUP;
    r = $urandom_range(0, 99);
    if (r < alloc_pct) begin
      queue_cmd(gsp_pkg::CMD_ALLOC, s, g);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        if (pick_live(s, g))
          queue_cmd(r < 45 ? gsp_pkg::CMD_RELEASE : gsp_pkg::CMD_LOOKUP, s, g);
        else queue_cmd(gsp_pkg::CMD_ALLOC, s, g);
      end else if (r < 80) begin
        if (pick_live(s, g)) begin
          if ($urandom_range(0, 1)) g = g ^ (16'd1 << $urandom_range(0, 15));
          else s = gsp_pkg::SIN_W'((s + $urandom_range(1, 3)) % cap_now);
        end
        queue_cmd(c, s, g);
      end else if (r < 90) begin
        queue_cmd(c, gsp_pkg::SIN_W'($urandom_range(cap_now, 255)), g);
      end else begin
        queue_cmd(gsp_pkg::CMD_W'($urandom_range(0, 3)), s, g);
      end
    end
  endtask

  initial begin
    int caps[8];
    int cap;
    caps = '{128, 1, 5, 128, 16, 2, 0, 128};

    queue_cmd(gsp_pkg::CMD_LOOKUP, 8'd0, 16'd0);
    queue_cmd(gsp_pkg::CMD_ALLOC, 8'hff, 16'hffff);
    queue_cmd(gsp_pkg::CMD_LOOKUP, 8'd0, 16'd1);
    queue_cmd(gsp_pkg::CMD_LOOKUP, 8'd0, 16'hffff);
    queue_cmd(gsp_pkg::CMD_RELEASE, 8'd0, 16'd1);
    queue_cmd(gsp_pkg::CMD_RELEASE, 8'd0, 16'd1);
    queue_cmd(gsp_pkg::CMD_ALLOC, 8'd0, 16'd0);
    queue_cmd(gsp_pkg::CMD_ALLOC, 8'd0, 16'd0);
    queue_cmd(gsp_pkg::CMD_LOOKUP, 8'd200, 16'd1);
    queue_cmd(gsp_pkg::CMD_LOOKUP, 8'd127, 16'd0);
    queue_cmd(CMD_NONE, 8'hff, 16'hffff);
    queue_cap(8'd2);
    queue_cmd(gsp_pkg::CMD_ALLOC, 8'd0, 16'd0);
    queue_cmd(gsp_pkg::CMD_ALLOC, 8'd0, 16'd0);
    queue_cmd(gsp_pkg::CMD_ALLOC, 8'd0, 16'd0);
    queue_cmd(gsp_pkg::CMD_RELEASE, 8'd1, 16'd1);
    queue_cmd(gsp_pkg::CMD_ALLOC, 8'd0, 16'd0);
    queue_cap(8'd0);
    queue_cap(8'd129);
    queue_cap(8'd255);
    queue_cmd(gsp_pkg::CMD_LOOKUP, 8'd0, 16'd1);
    queue_cmd(gsp_pkg::CMD_LOOKUP, 8'd2, 16'd0);
    queue_cap(8'd128);
    queue_cmd(gsp_pkg::CMD_LOOKUP, 8'd0, 16'd1);
    queue_cmd(gsp_pkg::CMD_ALLOC, 8'd0, 16'd0);
    queue_cap(8'd1);
    queue_cmd(gsp_pkg::CMD_ALLOC, 8'd0, 16'd0);
    queue_cmd(gsp_pkg::CMD_ALLOC, 8'd0, 16'd0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 8; p++) begin
      do @(negedge clk); while (op_q.size() != 0);
      if (p >= 6) steady = 1'b1;
      if ($urandom_range(0, 1))
        queue_cap($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(129, 255)));
      cap = caps[p] != 0 ? caps[p] : $urandom_range(1, 128);
      queue_cap(gsp_pkg::CNT_W'(cap));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        do @(negedge clk); while (op_q.size() != 0);
        if (n == PHASE_ITEMS / 2)
          op_q.insert(op_q.size(), '{OP_SETTLE, CMD_NONE, '0, '0, '0});
        queue_random_item(p == 0 ? 75 : 45);
      end
    end

    do @(negedge clk); while (op_q.size() != 0 || start || reply_q.size() != 0);
    repeat (6) @(posedge clk);
    if (reply_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("generational_slot_pool regression: pass");
    end else begin
      $display("generational_slot_pool regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/gsp_pkg.sv
rtl/gsp_ctrl.sv
rtl/gsp_dpath.sv
rtl/generational_slot_pool.sv
dv/tb_generational_slot_pool.sv
